// ----- design/homogeneous_vertex_transform_core_assert.svh -----
// Assertion macros for the homogeneous vertex transform core.
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_CORE_ASSERT_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define HVT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication with a fixed delay in cycles.
`define HVT_ASSERT_DLY(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("assertion failed");
`endif

// ----- design/hvt_pkg.sv -----
// ----------------------------------------------------------------------------
// hvt_pkg
// Types and constants shared by the vertex transform core.
// ----------------------------------------------------------------------------
package hvt_pkg;
    localparam int FRAC_BITS   = 16;
    localparam int W_MIN_LSB   = ((1 << FRAC_BITS) + 999999) / 1000000;
    localparam int NUM_REGS    = 8;
    localparam int CFG_W       = 64;
    localparam int IDX_W       = 3;
    localparam int QB          = 32 + FRAC_BITS + 1;     // dividend width (signed)
    localparam int DIV_STAGES  = QB;                    // one quotient bit per stage
    // accept edge to the edge that takes the result: input, product and sum
    // registers, divider setup plus stages, output register
    localparam int LAT         = 3 + DIV_STAGES + 2;

    localparam logic [IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } in_word_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } out_word_t;

    typedef logic signed [31:0] mat_t [4][4];
endpackage

// ----- design/hvt_lane.sv -----
// ----------------------------------------------------------------------------
// hvt_lane
// One matrix column: three products, exact sum, floor to Q16.16, range flag.
// ----------------------------------------------------------------------------
module hvt_lane
    import hvt_pkg::*;
(
    input  logic               clk,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    input  logic signed [31:0] m0,
    input  logic signed [31:0] m1,
    input  logic signed [31:0] m2,
    input  logic signed [31:0] m3,
    output logic signed [31:0] sum,
    output logic               ovf
);
    logic signed [63:0] p0_reg, p1_reg, p2_reg;
    logic signed [31:0] t_reg;
    logic signed [66:0] acc;
    logic signed [66:0] fl;

    always_ff @(posedge clk)
    begin
        p0_reg <= px * m0;
        p1_reg <= py * m1;
        p2_reg <= pz * m2;
        t_reg  <= m3;
    end

    always_comb
    begin
        acc = 67'(p0_reg) + 67'(p1_reg) + 67'(p2_reg)
            + (67'(t_reg) <<< FRAC_BITS);
        fl  = acc >>> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        sum <= fl[31:0];
        ovf <= (fl > 67'sd2147483647) || (fl < -67'sd2147483648);
    end
endmodule

// ----- design/hvt_div.sv -----
// ----------------------------------------------------------------------------
// hvt_div
// Pipelined restoring divider: one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module hvt_div
    import hvt_pkg::*;
(
    input  logic               clk,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic signed [31:0] quo,
    output logic               ovf
);
    logic [QB-1:0] q_reg [DIV_STAGES+1];
    logic [QB-1:0] r_reg [DIV_STAGES+1];
    logic [31:0]   d_reg [DIV_STAGES+1];
    logic          n_reg [DIV_STAGES+1];

    // stage 0: magnitudes of (num << FRAC_BITS) and den
    always_ff @(posedge clk)
    begin
        q_reg[0] <= num[31] ? QB'(-(QB'(signed'(num)) <<< FRAC_BITS))
                            : QB'(QB'(num) << FRAC_BITS);
        r_reg[0] <= '0;
        d_reg[0] <= den[31] ? 32'(-den) : 32'(den);
        n_reg[0] <= num[31] ^ den[31];
    end

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_st
        logic [QB:0] rs;
        logic [QB:0] df;
        always_comb
        begin
            rs = {r_reg[i], q_reg[i][QB-1]};
            df = rs - (QB+1)'(d_reg[i]);
        end
        always_ff @(posedge clk)
        begin
            r_reg[i+1] <= df[QB] ? rs[QB-1:0] : df[QB-1:0];
            q_reg[i+1] <= {q_reg[i][QB-2:0], ~df[QB]};
            d_reg[i+1] <= d_reg[i];
            n_reg[i+1] <= n_reg[i];
        end
    end

    logic [QB-1:0] mag;
    assign mag = q_reg[DIV_STAGES];
    assign quo = n_reg[DIV_STAGES] ? 32'(-mag) : mag[31:0];
    assign ovf = n_reg[DIV_STAGES] ? (mag > QB'(33'h80000000))
                                   : (mag > QB'(32'h7fffffff));
endmodule

// ----- design/homogeneous_vertex_transform_core.sv -----
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_core
// 4x4 matrix perspective transform of one Q16.16 point per cycle.
// ----------------------------------------------------------------------------
// A new point word may be started every cycle; each start yields exactly one
// result word, strobed by done for one cycle. Between start and result lie the
// input register and the product and Q16.16 sum registers in four column lanes,
// one divider setup stage, one pipelined divider stage per quotient bit (49 at
// Q16.16), then the output register. The receiver cannot stall: take the word
// in the cycle done is high. Write the matrix only with no word in flight.
// busy is always low.
module homogeneous_vertex_transform_core
    import hvt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_word_t         in_word,
    output logic             done,
    output out_word_t        out_word,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0] cfg_data
);
    logic [CFG_W-1:0] cfg_reg [NUM_REGS];
    logic [LAT-2:0]   vld_reg;
    logic signed [31:0] s [4];
    logic               so [4];
    logic signed [31:0] m [4][4];

    assign busy = 1'b0;

    // hold the matrix registers; reset to identity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                cfg_reg[i] <= '0;
            cfg_reg[REG_ROW0_COLS01] <= 64'd65536;
            cfg_reg[REG_ROW1_COLS01] <= 64'd281474976710656;
            cfg_reg[REG_ROW2_COLS23] <= 64'd65536;
            cfg_reg[REG_ROW3_COLS23] <= 64'd281474976710656;
        end
        else if (cfg_we)
            cfg_reg[cfg_idx] <= cfg_data;
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = (c % 2 == 1) ? cfg_reg[r*2 + c/2][63:32]
                                       : cfg_reg[r*2 + c/2][31:0];
    end

    // advance the valid marks alongside the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-3:0], start && !busy};
    end

    // input register
    in_word_t p_reg;
    always_ff @(posedge clk)
        p_reg <= in_word;

    for (genvar c = 0; c < 4; c++) begin : g_lane
        hvt_lane u_lane (
            .clk(clk), .px(p_reg.in_x), .py(p_reg.in_y), .pz(p_reg.in_z),
            .m0(m[0][c]), .m1(m[1][c]), .m2(m[2][c]), .m3(m[3][c]),
            .sum(s[c]), .ovf(so[c])
        );
    end

    // merge: flag bad sum or degenerate w, then divide the three lanes
    logic bad;
    assign bad = so[0] || so[1] || so[2] || so[3]
              || ((s[3] < 32'(W_MIN_LSB)) && (s[3] > -32'(W_MIN_LSB)));
    logic signed [31:0] w_safe;
    assign w_safe = bad ? 32'sd1 : s[3];

    logic [DIV_STAGES:0] bad_reg;
    always_ff @(posedge clk)
        bad_reg <= {bad_reg[DIV_STAGES-1:0], bad};

    logic signed [31:0] q [3];
    logic               qo [3];
    for (genvar c = 0; c < 3; c++) begin : g_div
        hvt_div u_div (.clk(clk), .num(s[c]), .den(w_safe), .quo(q[c]), .ovf(qo[c]));
    end

    logic fail;
    assign fail = bad_reg[DIV_STAGES] || qo[0] || qo[1] || qo[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= vld_reg[LAT-2];
    end

    always_ff @(posedge clk)
    begin
        out_word.ok    <= !fail;
        out_word.out_x <= fail ? '0 : q[0];
        out_word.out_y <= fail ? '0 : q[1];
        out_word.out_z <= fail ? '0 : q[2];
    end
endmodule

// ----- design/hvt_checker.sv -----
// ----------------------------------------------------------------------------
// hvt_checker
// Port-level checks on the vertex transform core, bound to the top level.
// ----------------------------------------------------------------------------
`include "homogeneous_vertex_transform_core_assert.svh"
module hvt_checker
    import hvt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input out_word_t out_word
);
    `HVT_ASSERT_DLY(a_start_done, start && !busy, LAT, done)
    `HVT_ASSERT_IMP(a_fail_zero, done && !out_word.ok, out_word[95:0] == 96'd0)
    `HVT_ASSERT_IMP(a_never_busy, 1'b1, !busy)
endmodule

bind homogeneous_vertex_transform_core hvt_checker u_hvt_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .out_word(out_word)
);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the homogeneous vertex transform core. It loads
// several 4x4 matrices, including extremes, and streams point words with
// random gaps. Each point is predicted with exact wide integer arithmetic.
// Each strobed result word is checked field by field against that prediction.
// ----------------------------------------------------------------------------
module tb;
    import hvt_pkg::*;

    localparam int LIMIT = 400000;

    // Expected-result store plus an independent copy of the matrix.
    class transform_scoreboard;
        mat_t      m;
        out_word_t pending [$];
        int        mismatches;

        function void load_reg(int idx, logic [63:0] v);
            m[idx / 2][(idx % 2) * 2]     = v[31:0];
            m[idx / 2][(idx % 2) * 2 + 1] = v[63:32];
        endfunction

        // Exact column sums, floor to the fraction width, then the w divide.
        function out_word_t project(in_word_t p);
            logic signed [31:0] pt [3];
            logic signed [79:0] acc;
            logic signed [79:0] s [4];
            logic signed [79:0] ext;
            logic signed [63:0] num;
            logic signed [63:0] den;
            logic signed [63:0] q [3];
            logic signed [63:0] qx;
            bit                 good;
            out_word_t          r;
            pt[0] = p.in_x;
            pt[1] = p.in_y;
            pt[2] = p.in_z;
            good  = 1'b1;
            for (int c = 0; c < 4; c++)
            begin
                acc = m[3][c];
                acc = acc <<< FRAC_BITS;
                for (int k = 0; k < 3; k++)
                    acc = acc + pt[k] * m[k][c];
                s[c] = acc >>> FRAC_BITS;
                ext  = $signed(s[c][31:0]);
                if (ext != s[c])
                    good = 1'b0;
            end
            if (good && s[3] < W_MIN_LSB && s[3] > -W_MIN_LSB)
                good = 1'b0;
            if (good)
            begin
                den = s[3][63:0];
                for (int c = 0; c < 3; c++)
                begin
                    num  = s[c][63:0];
                    q[c] = (num <<< FRAC_BITS) / den;
                    qx   = $signed(q[c][31:0]);
                    if (qx != q[c])
                        good = 1'b0;
                end
            end
            r.ok    = good;
            r.out_x = good ? q[0][31:0] : '0;
            r.out_y = good ? q[1][31:0] : '0;
            r.out_z = good ? q[2][31:0] : '0;
            return r;
        endfunction

        function void note_point(in_word_t p);
            pending.push_back(project(p));
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.ok !== want.ok || got.out_x !== want.out_x ||
                got.out_y !== want.out_y || got.out_z !== want.out_z)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: ok %b/%b x %h/%h y %h/%h z %h/%h (exp/act)",
                             want.ok, got.ok, want.out_x, got.out_x,
                             want.out_y, got.out_y, want.out_z, got.out_z);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  in_word;
    logic      done;
    out_word_t out_word;
    logic      cfg_we;
    logic [IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;
    int        cycles;
    bit        steady;

    transform_scoreboard sb;

    homogeneous_vertex_transform_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .in_word  (in_word),
        .done     (done),
        .out_word (out_word),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    // Watchdog: a hung pipeline ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // The receiver cannot stall, so take every strobed word as it comes.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(out_word);
    end

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(60, 8);
    endfunction

    // Hold start high until the word is taken, then drop it for the gap.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        in_word_t p;
        int       gap;
        p.in_x = x;
        p.in_y = y;
        p.in_z = z;
        start   <= 1'b1;
        in_word <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_point(p);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every word in flight has come back.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LAT + 2) @(posedge clk);
    endtask

    // Write all eight registers from a matrix; call only when drained.
    task automatic load_matrix(mat_t mm);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_idx  <= i[IDX_W-1:0];
            cfg_data <= {mm[i / 2][(i % 2) * 2 + 1], mm[i / 2][(i % 2) * 2]};
            @(posedge clk);
            sb.load_reg(i, {mm[i / 2][(i % 2) * 2 + 1], mm[i / 2][(i % 2) * 2]});
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return int'($urandom_range(2 ** 21)) - 2 ** 20;
        if (r < 85)
            return int'($urandom_range(2 ** 27)) - 2 ** 26;
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_entry(int mag);
        return int'($urandom_range(2 * mag)) - mag;
    endfunction

    // Matrix flavors: perspective, affine, full random, all zero, all ones.
    function automatic mat_t make_matrix(int kind);
        mat_t mm;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                case (kind)
                    0: mm[r][c] = (c == 3) ? rand_entry(2 ** 14) : rand_entry(2 ** 18);
                    1: mm[r][c] = (c == 3) ? 32'sh0 : rand_entry(2 ** 18);
                    2: mm[r][c] = $urandom;
                    3: mm[r][c] = 32'sh0;
                    default: mm[r][c] = 32'hffff_ffff;
                endcase
        if (kind <= 1)
            mm[3][3] = 32'sh0001_0000 + ((kind == 0) ? rand_entry(2 ** 15) : 32'sh0);
        return mm;
    endfunction

    function automatic mat_t identity();
        mat_t mm;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                mm[r][c] = (r == c) ? 32'sh0001_0000 : 32'sh0;
        return mm;
    endfunction

    int   kinds [7] = '{0, 1, 2, 3, 4, 0, 1};
    int   counts [7] = '{300, 300, 150, 60, 60, 300, 180};
    mat_t mm;

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        start    = 1'b0;
        in_word  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        cycles   = 0;
        steady   = 1'b0;
        sb       = new();
        for (int i = 0; i < NUM_REGS; i++)
            sb.load_reg(i, (i == REG_ROW0_COLS01 || i == REG_ROW2_COLS23) ? 64'd65536 :
                           (i == REG_ROW1_COLS01 || i == REG_ROW3_COLS23) ?
                           64'd281474976710656 : 64'd0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity after reset: field extremes pass straight through.
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h1);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        send_point(32'hffff_ffff, 32'h1, 32'h0);
        send_point(32'h0001_0000, 32'hffff_0000, 32'h1234_5678);
        drain();

        // Perspective divide by z: zero w, tiny w, negative w, truncation.
        mm = identity();
        mm[2][3] = 32'sh0001_0000;
        mm[3][3] = 32'sh0;
        load_matrix(mm);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0);
        send_point(32'h0001_0000, 32'h0, 32'h1);
        send_point(32'h0004_0000, 32'hfffc_0000, 32'h0002_0000);
        send_point(32'h0003_0000, 32'h0001_8000, 32'hffff_0000);
        send_point(32'hffff_fffd, 32'h0000_0003, 32'hffff_8000);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        drain();

        // Half-scale entries: floor rounding of negative sums, sum overflow.
        mm = identity();
        mm[0][0] = 32'sh0000_8000;
        mm[1][1] = 32'shffff_8000;
        mm[2][2] = 32'sh7fff_ffff;
        mm[3][0] = 32'sh8000_0000;
        load_matrix(mm);
        send_point(32'hffff_ffff, 32'hffff_ffff, 32'h0);
        send_point(32'h1, 32'h1, 32'h0);
        send_point(32'h0, 32'h0, 32'h1);
        send_point(32'h0, 32'h0, 32'h7fff_ffff);
        send_point(32'hffff_fffd, 32'h3, 32'h0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        drain();

        // Random phases, each under its own matrix.
        for (int ph = 0; ph < 7; ph++)
        begin
            mm = make_matrix(kinds[ph]);
            load_matrix(mm);
            steady = ($urandom_range(3) == 0);
            for (int n = 0; n < counts[ph]; n++)
            begin
                if (n == counts[ph] / 2)
                    drain();
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

// ----- homogeneous_vertex_transform_core.f -----
+incdir+design
design/hvt_pkg.sv
design/hvt_lane.sv
design/hvt_div.sv
design/homogeneous_vertex_transform_core.sv
design/hvt_checker.sv
verif/tb.sv
